// ----- design/fgnh_pkg.sv -----
`timescale 1ns / 1ps
package fgnh_pkg;

	localparam int MAX_OCTAVES = 8;
	localparam int WORLD_ROWS  = 4096;
	localparam int NUM_STAGES  = 33;

	localparam logic [31:0] HASH_K1 = 32'd374761393;
	localparam logic [31:0] HASH_K2 = 32'd1274126177;
	localparam logic [16:0] SEED_K  = 17'd69069;
	localparam logic [23:0] RECIP25 = 24'd10737419;
	localparam logic [16:0] AMP_ONE = 17'd65536;

	localparam logic [31:0] SEED_RST    = 32'd0;
	localparam logic [3:0]  OCTAVES_RST = 4'd8;
	localparam logic [15:0] PERSIST_RST = 16'd32768;
	localparam logic [12:0] START_RST   = 13'd1000;
	localparam logic [9:0]  SCALE_RST   = 10'd200;
	localparam logic [19:0] WEIGHT_RST  = 20'd130560;

	localparam logic [13:0] FRAC_TAB [25] = '{
		14'd0,     14'd655,   14'd1310,  14'd1966,  14'd2621,
		14'd3276,  14'd3932,  14'd4587,  14'd5242,  14'd5898,
		14'd6553,  14'd7208,  14'd7864,  14'd8519,  14'd9175,
		14'd9830,  14'd10485, 14'd11141, 14'd11796, 14'd12451,
		14'd13107, 14'd13762, 14'd14417, 14'd15073, 14'd15728
	};

	typedef enum logic [2:0] {
		REG_SEED    = 3'd0,
		REG_OCTAVES = 3'd1,
		REG_PERSIST = 3'd2,
		REG_START   = 3'd3,
		REG_SCALE   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] seedk;
		logic [16:0] amp;
	} lane_cfg_t;

endpackage

// ----- design/fgnh_octave.sv -----
`timescale 1ns / 1ps
module fgnh_octave (
	input  logic                      clk,
	input  logic                      en,
	input  logic [22:0]               x,
	input  fgnh_pkg::lane_cfg_t       cfg,
	output logic signed [35:0]        w
);
	import fgnh_pkg::*;

	function automatic logic signed [17:0] grad(input logic [31:0] m);
		logic [31:0] h;
		logic [16:0] hi;
		logic [32:0] sum;
		logic [17:0] q;
		h   = m ^ (m >> 16);
		hi  = h[31:15];
		sum = 33'(hi) + {1'b0, h[14:0], 17'd0};
		q   = 18'(hi) + 18'(sum >= 33'h0FFFFFFFF);
		return $signed(q - 18'd65536);
	endfunction

	logic [46:0] prod_s1;
	logic [22:0] x_s1;
	logic [18:0] q1;
	logic [22:0] rem25;
	logic [4:0]  r1;
	logic [16:0] cell_s2;
	logic [15:0] f_s2, f_s3, f_s4, f_s5, f_s6;
	logic [31:0] ha_s3, hb, xa, xb, ma_s4, mb_s4;
	logic signed [17:0] ga_s5, gb_s5;
	logic signed [34:0] pa_s6, pa_adj;
	logic signed [35:0] pb_s6, pb_adj;
	logic [31:0] ff_s6;
	logic signed [17:0] da_s7, db_s7, da_s8;
	logic [49:0] sp_s7;
	logic signed [18:0] diff;
	logic signed [35:0] t_s8, t_adj;
	logic signed [17:0] n_s9;

	assign q1    = prod_s1[46:28];
	assign rem25 = x_s1 - 23'(q1) * 23'd25;
	assign r1    = rem25[4:0];

	assign hb = ha_s3 + HASH_K1;
	assign xa = ha_s3 ^ (ha_s3 >> 13);
	assign xb = hb ^ (hb >> 13);

	assign pa_adj = pa_s6 + (pa_s6[34] ? 35'sd65535 : 35'sd0);
	assign pb_adj = pb_s6 + (pb_s6[35] ? 36'sd65535 : 36'sd0);

	assign diff  = 19'(db_s7) - 19'(da_s7);
	assign t_adj = t_s8 + (t_s8[35] ? 36'sd65535 : 36'sd0);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 47'(x) * 47'(RECIP25);
			x_s1    <= x;
			cell_s2 <= q1[18:2];
			f_s2    <= {q1[1:0], FRAC_TAB[r1]};
			ha_s3   <= 32'(cell_s2) * HASH_K1 + cfg.seedk;
			f_s3    <= f_s2;
			ma_s4   <= xa * HASH_K2;
			mb_s4   <= xb * HASH_K2;
			f_s4    <= f_s3;
			ga_s5   <= grad(ma_s4);
			gb_s5   <= grad(mb_s4);
			f_s5    <= f_s4;
			pa_s6   <= ga_s5 * $signed({1'b0, f_s5});
			pb_s6   <= gb_s5 * $signed({2'b11, f_s5});
			ff_s6   <= 32'(f_s5) * 32'(f_s5);
			f_s6    <= f_s5;
			da_s7   <= 18'(pa_adj >>> 16);
			db_s7   <= 18'(pb_adj >>> 16);
			sp_s7   <= 50'(ff_s6) * 50'(18'd196608 - {1'b0, f_s6, 1'b0});
			t_s8    <= $signed({1'b0, sp_s7[47:32]}) * diff;
			da_s8   <= da_s7;
			n_s9    <= 18'(19'(da_s8) + 19'(t_adj >>> 16));
			w       <= n_s9 * $signed({1'b0, cfg.amp});
		end
	end

endmodule

// ----- design/fractal_gradient_noise_height.sv -----
`timescale 1ns / 1ps
// Fractal 1D gradient noise surface height, one column per transaction.
// Input stream: s_tdata carries the world column. Output stream: m_tdata
// carries the normalized noise and the surface row, m_tuser the clamp flag.
// Configuration: cfg_index selects seed, octave count, persistence, start
// row or height scale; cfg_ready is always high and unknown indexes drop.
// Write configuration only while no transaction is in flight; derived
// seed and amplitude terms settle after a write, well before any new
// column reaches the stages that use them.
// Throughput: one column per cycle while the output is not stalled. Depth
// is set by the octave lanes (10 stages, all octaves in parallel), a
// 3-stage adder tree, the sign/magnitude stage, a 17-stage restoring
// divider (one quotient bit per stage) and 2 stages of saturation and
// row scaling.
// When the receiver stalls a valid result, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the default configuration.
module fractal_gradient_noise_height (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] column
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [17:0] noise_value, [30:18] surface_row, [31] zero
	output logic [0:0]  m_tuser,   // [0] row_clamped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import fgnh_pkg::*;

	logic        en;
	logic [NUM_STAGES-1:0] vld_q;

	logic [31:0] noise_seed_q;
	logic [3:0]  octave_count_q;
	logic [15:0] persistence_q;
	logic [12:0] start_row_q;
	logic [9:0]  height_scale_q;
	logic [31:0] seedk_q;
	logic [16:0] amp_q [MAX_OCTAVES];
	logic [19:0] weight_q;
	logic [19:0] weight_sum;
	logic [3:0]  noct;

	logic signed [35:0] w_lane [MAX_OCTAVES];
	logic signed [38:0] sum1_s11 [4];
	logic signed [38:0] sum2_s12 [2];
	logic signed [38:0] total_s13;

	logic [36:0] rem_s [0:17];
	logic [16:0] quo_s [0:17];
	logic        neg_s [0:17];

	logic [16:0] qsat;
	logic signed [17:0] noise;
	logic signed [17:0] noise_s32, noise_s33;
	logic signed [28:0] rp_s32;
	logic signed [30:0] v, v_adj;
	logic signed [14:0] row_t;
	logic [12:0] row_s33;
	logic        clamp_s33;

	assign en        = !vld_q[NUM_STAGES-1] || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = vld_q[NUM_STAGES-1];
	assign m_tdata   = {1'b0, row_s33, noise_s33};
	assign m_tuser   = clamp_s33;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NUM_STAGES-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_seed_q   <= SEED_RST;
			octave_count_q <= OCTAVES_RST;
			persistence_q  <= PERSIST_RST;
			start_row_q    <= START_RST;
			height_scale_q <= SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SEED:    noise_seed_q   <= cfg_data;
				REG_OCTAVES: octave_count_q <= cfg_data[3:0];
				REG_PERSIST: persistence_q  <= cfg_data[15:0];
				REG_START:   start_row_q    <= cfg_data[12:0];
				REG_SCALE:   height_scale_q <= cfg_data[9:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		if (octave_count_q == 4'd0)
			noct = 4'd1;
		else if (octave_count_q > 4'(MAX_OCTAVES))
			noct = 4'(MAX_OCTAVES);
		else
			noct = octave_count_q;
	end

	always_comb begin
		weight_sum = '0;
		for (int k = 0; k < MAX_OCTAVES; k++) begin
			if (4'(k) < noct)
				weight_sum = weight_sum + 20'(amp_q[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seedk_q  <= '0;
			weight_q <= WEIGHT_RST;
			for (int k = 0; k < MAX_OCTAVES; k++)
				amp_q[k] <= AMP_ONE >> k;
		end else begin
			seedk_q  <= noise_seed_q * 32'(SEED_K);
			weight_q <= weight_sum;
			amp_q[0] <= AMP_ONE;
			for (int k = 1; k < MAX_OCTAVES; k++)
				amp_q[k] <= 17'((33'(amp_q[k-1]) * 33'(persistence_q)) >> 16);
		end
	end

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
		fgnh_octave u_octave (
			.clk (clk),
			.en  (en),
			.x   (23'(s_tdata) << i),
			.cfg ('{seedk: seedk_q, amp: amp_q[i]}),
			.w   (w_lane[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++)
				sum1_s11[k] <= (4'(2*k) < noct ? 39'(w_lane[2*k]) : 39'sd0)
					+ (4'(2*k+1) < noct ? 39'(w_lane[2*k+1]) : 39'sd0);
			sum2_s12[0] <= sum1_s11[0] + sum1_s11[1];
			sum2_s12[1] <= sum1_s11[2] + sum1_s11[3];
			total_s13   <= sum2_s12[0] + sum2_s12[1];
			neg_s[0]    <= total_s13[38];
			rem_s[0]    <= 37'(total_s13[38] ? -total_s13 : total_s13);
			quo_s[0]    <= '0;
		end
	end

	for (genvar d = 0; d < 17; d++) begin : g_div
		logic [36:0] cand;
		logic        ge;
		assign cand = 37'(weight_q) << (16 - d);
		assign ge   = rem_s[d] >= cand;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[d+1] <= ge ? rem_s[d] - cand : rem_s[d];
				quo_s[d+1] <= quo_s[d] | (17'(ge) << (16 - d));
				neg_s[d+1] <= neg_s[d];
			end
		end
	end

	assign qsat  = (quo_s[17] > 17'd65536) ? 17'd65536 : quo_s[17];
	assign noise = neg_s[17] ? -$signed(18'(qsat)) : $signed(18'(qsat));

	assign v      = 31'(rp_s32) + $signed(31'({start_row_q, 16'd0}));
	assign v_adj  = v + (v[30] ? 31'sd65535 : 31'sd0);
	assign row_t  = 15'(v_adj >>> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			noise_s32 <= noise;
			rp_s32    <= noise * $signed({1'b0, height_scale_q});
			noise_s33 <= noise_s32;
			if (row_t[14]) begin
				row_s33   <= '0;
				clamp_s33 <= 1'b1;
			end else if (row_t > 15'(WORLD_ROWS)) begin
				row_s33   <= 13'(WORLD_ROWS);
				clamp_s33 <= 1'b1;
			end else begin
				row_s33   <= row_t[12:0];
				clamp_s33 <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_clamp_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[30:18] == 13'd0 || m_tdata[30:18] == 13'(WORLD_ROWS)))
		else $error("clamped row not at a range limit");
	a_noise_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[17:0]) >= -18'sd65536 && $signed(m_tdata[17:0]) <= 18'sd65536))
		else $error("noise out of range");
	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		weight_q >= 20'(AMP_ONE))
		else $error("amplitude sum below one");
`endif

endmodule

// ----- tb/height_checker.sv -----
`timescale 1ns / 1ps
module height_checker
	import fgnh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [17:0] noise;
		logic [12:0] row;
		logic        clamped;
	} height_t;

	height_t     expected_heights[$];
	logic [31:0] seed;
	logic [3:0]  octaves;
	logic [15:0] persist;
	logic [12:0] start;
	logic [9:0]  scale;

	function automatic logic [31:0] cell_hash(logic [31:0] lattice_idx, logic [31:0] sd);
		logic [31:0] h;
		h = lattice_idx * HASH_K1 + sd * 32'(SEED_K);
		h = (h ^ (h >> 13)) * HASH_K2;
		return h ^ (h >> 16);
	endfunction

	function automatic longint gradient(logic [31:0] lattice_idx);
		logic [63:0] sc;
		sc = ({32'd0, cell_hash(lattice_idx, seed)} << 17) / 64'hFFFF_FFFF;
		return longint'(sc) - 65536;
	endfunction

	function automatic longint octave_noise(logic [15:0] col, int shift);
		logic [63:0] p;
		logic [31:0] lattice_idx;
		longint f, ga, gb, da, db, s;
		p = ((64'(col) << shift) << 16) / 64'd100;
		lattice_idx = p[47:16];
		f = longint'(p[15:0]);
		ga = gradient(lattice_idx);
		gb = gradient(lattice_idx + 32'd1);
		da = (ga * f) / 65536;
		db = (gb * (f - 65536)) / 65536;
		s = (f * f * (3 * 65536 - 2 * f)) / (64'sd1 <<< 32);
		return da + (s * (db - da)) / 65536;
	endfunction

	function automatic height_t predict_height(logic [15:0] col);
		height_t r;
		int n;
		longint total, weight, amp, noise, row;
		n = (octaves == 0) ? 1 : (octaves > MAX_OCTAVES ? MAX_OCTAVES : int'(octaves));
		total = 0;
		weight = 0;
		amp = 65536;
		for (int i = 0; i < n; i++) begin
			total += octave_noise(col, i) * amp;
			weight += amp;
			amp = (amp * longint'(persist)) / 65536;
		end
		noise = total / weight;
		if (noise > 65536) noise = 65536;
		if (noise < -65536) noise = -65536;
		row = (noise * longint'(scale) + longint'(start) * 65536) / 65536;
		r.clamped = 1'b0;
		if (row < 0) begin
			row = 0;
			r.clamped = 1'b1;
		end else if (row > WORLD_ROWS) begin
			row = WORLD_ROWS;
			r.clamped = 1'b1;
		end
		r.noise = noise[17:0];
		r.row = row[12:0];
		return r;
	endfunction

	assign pending = expected_heights.size();

	always @(posedge clk or negedge arst_n) begin
		height_t got, want;
		if (!arst_n) begin
			seed <= SEED_RST;
			octaves <= OCTAVES_RST;
			persist <= PERSIST_RST;
			start <= START_RST;
			scale <= SCALE_RST;
			fail_count <= 0;
			expected_heights.delete();
		end else begin
			if (s_tvalid && s_tready)
				expected_heights.push_back(predict_height(s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[17:0], m_tdata[30:18], m_tuser[0]};
				if (expected_heights.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_heights.pop_front();
					if (got.noise !== want.noise || got.row !== want.row ||
					    got.clamped !== want.clamped) begin
						$display("%0t: mismatch, expected noise %h row %0d clamp %b, actual noise %h row %0d clamp %b",
							$time, want.noise, want.row, want.clamped,
							got.noise, got.row, got.clamped);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SEED:    seed <= cfg_data;
					REG_OCTAVES: octaves <= cfg_data[3:0];
					REG_PERSIST: persist <= cfg_data[15:0];
					REG_START:   start <= cfg_data[12:0];
					REG_SCALE:   scale <= cfg_data[9:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import fgnh_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          fail_count, pending;
	int          send_idle_pct, recv_idle_pct;
	int          cycles;

	fractal_gradient_noise_height i_dut (.*);

	height_checker i_checker (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

	task automatic send_column(logic [15:0] col);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = col;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(logic [31:0] sd, logic [3:0] oc, logic [15:0] pr,
				logic [12:0] st, logic [9:0] sc);
		drain();
		write_reg(REG_SEED, sd);
		write_reg(REG_OCTAVES, {28'd0, oc});
		write_reg(REG_PERSIST, {16'd0, pr});
		write_reg(REG_START, {19'd0, st});
		write_reg(REG_SCALE, {22'd0, sc});
	endtask

	task automatic send_edges;
		send_column(16'd0);
		send_column(16'hFFFF);
		send_column(16'd99);
		send_column(16'd100);
		send_column(16'h8000);
		send_column(16'h5555);
		send_column(16'hAAAA);
	endtask

	initial begin
		arst_n = 1'b0;
		cycles = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SEED;
		cfg_data = '0;
		send_idle_pct = 34;
		recv_idle_pct = 52;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_edges();
		write_all(32'h7FFF_FFFF, 4'd0, 16'd0, 13'd0, 10'd1023);
		send_edges();
		write_all(32'h8000_0000, 4'd15, 16'hFFFF, 13'd4096, 10'd1023);
		write_reg(cfg_reg_t'(3'd5), 32'hFFFF_FFFF);
		write_reg(cfg_reg_t'(3'd6), 32'd0);
		write_reg(cfg_reg_t'(3'd7), 32'd1);
		send_edges();
		write_all(32'hFFFF_FFFF, 4'd1, 16'd1, 13'h1FFF, 10'd0);
		send_column(16'd12345);

		for (int k = 0; k < 750; k++) begin
			if (k == 250) begin
				send_idle_pct = 52;
				recv_idle_pct = 34;
			end else if (k == 500) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (k % 60 == 59)
				write_all($urandom, 4'($urandom_range(15)), 16'($urandom),
					13'($urandom_range(8191)), 10'($urandom));
			send_column(16'($urandom));
		end
		drain();
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- fractal_gradient_noise_height.f -----
design/fgnh_pkg.sv
design/fgnh_octave.sv
design/fractal_gradient_noise_height.sv
tb/height_checker.sv
tb/tb_top.sv
